### src/grid_zorder_index_codec_defines.svh
// Assertion macros shared by the grid Z-order index codec RTL.
// Included by files that carry concurrent assertions; empty under synthesis.
`ifndef GRID_ZORDER_INDEX_CODEC_DEFINES_SVH
`define GRID_ZORDER_INDEX_CODEC_DEFINES_SVH
`ifndef SYNTHESIS
`define GZIC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("gzic assertion failed");
`define GZIC_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("gzic assertion failed");
`else
`define GZIC_ASSERT(lbl, prop)
`define GZIC_NEVER(lbl, expr)
`endif
`endif

### src/gzic_pkg.sv
// Shared types and constants for the grid Z-order index codec.
// No dependencies; imported by the top level and the bench.
package gzic_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int IDX_W          = 30;
	localparam int SIZE_W         = 11;
	localparam int CFG_IDX_W      = 2;
	localparam int HOLD_W         = 2;

	// reload value of the counter that holds the input off after a register write (derived-value chain)
	localparam logic [HOLD_W-1:0] CFG_HOLD = 2'd3;

	localparam logic [SIZE_W-1:0] SIZE_RST = 11'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THREE_D = 2'd0,
		REG_SIZE_X  = 2'd1,
		REG_SIZE_Y  = 2'd2,
		REG_SIZE_Z  = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} opcode_t;

endpackage

### src/gzic_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; a payload vector travels with each operand pair.
module gzic_div #(
	parameter int NW = 30,
	parameter int DW = 22,
	parameter int QB = 10,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [PW-1:0] pay_in,
	output logic          out_vld,
	output logic [QB-1:0] quo,
	output logic [NW-1:0] rem,
	output logic [PW-1:0] pay_out
);

	localparam int XW = NW + QB;

	logic          vld_q [QB];
	logic [NW-1:0] rem_q [QB];
	logic [DW-1:0] den_q [QB];
	logic [QB-1:0] quo_q [QB];
	logic [PW-1:0] pay_q [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int SH = QB - 1 - k;
		logic          vld_i;
		logic [NW-1:0] rem_i;
		logic [DW-1:0] den_i;
		logic [QB-1:0] quo_i;
		logic [PW-1:0] pay_i;
		logic [XW-1:0] dsh_c;
		logic [XW-1:0] rx_c;
		logic          ge_c;

		if (k == 0) begin : g_first
			assign vld_i = in_vld;
			assign rem_i = num;
			assign den_i = den;
			assign quo_i = '0;
			assign pay_i = pay_in;
		end else begin : g_next
			assign vld_i = vld_q[k-1];
			assign rem_i = rem_q[k-1];
			assign den_i = den_q[k-1];
			assign quo_i = quo_q[k-1];
			assign pay_i = pay_q[k-1];
		end

		// try subtracting the divisor aligned to this quotient bit
		assign dsh_c = XW'(den_i) << SH;
		assign rx_c  = XW'(rem_i);
		assign ge_c  = rx_c >= dsh_c;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge_c ? NW'(rx_c - dsh_c) : rem_i;
				den_q[k] <= den_i;
				quo_q[k] <= ge_c ? (quo_i | (QB'(1) << SH)) : quo_i;
				pay_q[k] <= pay_i;
			end
		end
	end

	assign out_vld = vld_q[QB-1];
	assign quo     = quo_q[QB-1];
	assign rem     = rem_q[QB-1];
	assign pay_out = pay_q[QB-1];

endmodule

### src/grid_zorder_index_codec.sv
// Grid Z-order index codec: maps 2D/3D cell coordinates to a storage index and back.
// Depends on gzic_pkg, gzic_div and grid_zorder_index_codec_defines.svh.
//
// One transaction per clock in either direction (tuser 0 encode, 1 decode) unless the
// pipeline is held or the input is held off, as below. Decode runs two restoring dividers
// in series, each spending one register stage per quotient bit, and encode results ride
// along the same stages. When the output is held, the whole pipeline holds with it. Grid
// sizes feed a three-register chain of derived values, so the input is not ready in the
// cycle of any register write nor while the hold counter reloaded by that write runs
// down; right after reset the input is likewise not ready until that counter is empty.
`include "grid_zorder_index_codec_defines.svh"
module grid_zorder_index_codec import gzic_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [SIZE_W-1:0]    cfg_wdata,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// coord_x, coord_y, coord_z, linear_index (lowest bits first), zero padded
	input  logic [((3*COORD_BITS+IDX_W+7)/8)*8-1:0] s_axis_tdata,
	// opcode
	input  logic                 s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// index_out, x_out, y_out, z_out (lowest bits first), zero padded
	output logic [((3*COORD_BITS+IDX_W+7)/8)*8-1:0] m_axis_tdata,
	// out_of_range
	output logic                 m_axis_tuser
);

	localparam int CB   = COORD_BITS;
	localparam int SW   = CB + 1;
	localparam int LW   = $clog2(SW);
	localparam int PLW  = 2 * SW;
	localparam int TW   = 3 * SW;
	localparam int AW   = (TW > IDX_W) ? TW : IDX_W;
	localparam int KW   = (SIZE_W > SW) ? SIZE_W : SW;
	localparam int MW   = 3 * CB;
	localparam int DPAD = ((3*CB+IDX_W+7)/8)*8;
	localparam logic [KW-1:0] SPAN_K = KW'(1) << CB;

	typedef struct packed {
		opcode_t          op;
		logic             bad;
		logic             dmor;
		logic             top;
		logic [IDX_W-1:0] eidx;
		logic [CB-1:0]    dx;
		logic [CB-1:0]    dy;
		logic [CB-1:0]    dz;
	} pay1_t;

	typedef struct packed {
		pay1_t         p1;
		logic          oxf;
		logic          oyf;
		logic [CB-1:0] oz;
	} pay2_t;

	// ---------------- configuration registers ----------------
	logic              three_d_q;
	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [HOLD_W-1:0] hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			three_d_q <= 1'b0;
			size_x_q  <= SIZE_RST;
			size_y_q  <= SIZE_RST;
			size_z_q  <= SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_THREE_D: three_d_q <= cfg_wdata[0];
				REG_SIZE_X:  size_x_q  <= cfg_wdata;
				REG_SIZE_Y:  size_y_q  <= cfg_wdata;
				REG_SIZE_Z:  size_z_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= CFG_HOLD;
		end else if (cfg_we) begin
			hold_q <= CFG_HOLD;
		end else if (hold_q != '0) begin
			hold_q <= hold_q - HOLD_W'(1);
		end
	end

	// ---------------- derived grid values, level 1 ----------------
	logic [KW-1:0] sx_k, sy_k, sz_k;
	logic [SW-1:0] cx_c, cy_c, cz_c, mxy_c, mn_c;
	logic [SW-1:0] nx_q, ny_q, nz_q, mn_q;
	logic          d3_q;

	always_comb begin
		sx_k  = KW'(size_x_q);
		sy_k  = KW'(size_y_q);
		sz_k  = KW'(size_z_q);
		cx_c  = (sx_k > SPAN_K) ? SW'(SPAN_K) : SW'(sx_k);
		cy_c  = (sy_k > SPAN_K) ? SW'(SPAN_K) : SW'(sy_k);
		cz_c  = three_d_q ? ((sz_k > SPAN_K) ? SW'(SPAN_K) : SW'(sz_k)) : SW'(1);
		mxy_c = (cx_c < cy_c) ? cx_c : cy_c;
		mn_c  = (three_d_q && cz_c < mxy_c) ? cz_c : mxy_c;
	end

	always_ff @(posedge clk) begin
		nx_q <= cx_c;
		ny_q <= cy_c;
		nz_q <= cz_c;
		mn_q <= mn_c;
		d3_q <= three_d_q;
	end

	// ---------------- level 2: cube side and plane ----------------
	logic [SW-1:0]  w_c, w_q;
	logic [LW-1:0]  lw_c, lw_q;
	logic           zero_q;
	logic [PLW-1:0] plane_q;

	always_comb begin
		w_c  = SW'(1);
		lw_c = '0;
		// highest set bit wins
		for (int i = 0; i < SW; i++) begin
			if (mn_q[i]) begin
				w_c  = SW'(1) << i;
				lw_c = LW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		w_q     <= w_c;
		lw_q    <= lw_c;
		zero_q  <= (mn_q == '0);
		plane_q <= PLW'(nx_q) * PLW'(ny_q);
	end

	// ---------------- level 3: region bases and limits ----------------
	logic [SW-1:0]  oddw_q;
	logic [PLW-1:0] ww_c, oddplane_q, oddww_q;
	logic [AW-1:0]  www_c, zc_q, total_q, wplane_q;
	logic [TW-1:0]  total_c;

	assign ww_c    = PLW'(1) << (2 * lw_q);
	assign www_c   = AW'(1) << (3 * lw_q);
	assign total_c = TW'(plane_q) * TW'(nz_q);

	always_ff @(posedge clk) begin
		oddw_q     <= nx_q - w_q;
		zc_q       <= d3_q ? www_c : AW'(ww_c);
		total_q    <= AW'(total_c);
		oddplane_q <= plane_q - ww_c;
		oddww_q    <= PLW'(nx_q - w_q) << lw_q;
		wplane_q   <= AW'(plane_q) << lw_q;
	end

	// ---------------- stage 1: input register ----------------
	logic          en;
	logic          vld_s1;
	opcode_t       op_s1;
	logic [CB-1:0] x_s1, y_s1, z_s1;
	logic [IDX_W-1:0] n_s1;
	logic          vld_s4;

	assign en            = !vld_s4 || m_axis_tready;
	assign s_axis_tready = en && (hold_q == '0) && !cfg_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid && s_axis_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= opcode_t'(s_axis_tuser);
			x_s1  <= s_axis_tdata[CB-1:0];
			y_s1  <= s_axis_tdata[2*CB-1:CB];
			z_s1  <= s_axis_tdata[3*CB-1:2*CB];
			n_s1  <= s_axis_tdata[3*CB+IDX_W-1:3*CB];
		end
	end

	// ---------------- stage 2: classify, multiply, divider prep ----------------
	logic [CB-1:0]  zz_c, a1_c;
	logic           xlow_c, ylow_c, zlow_c, bad_c, top_c;
	logic [SW-1:0]  b1_c;
	logic [PLW-1:0] b2_c;
	logic [AW-1:0]  add_c, nx_a, num1_c;
	logic [MW-1:0]  mor2_c, mor3_c, nw_c;
	logic [CB-1:0]  dmx_c, dmy_c, dmz_c;

	always_comb begin
		zz_c   = d3_q ? z_s1 : '0;
		xlow_c = SW'(x_s1) < w_q;
		ylow_c = SW'(y_s1) < w_q;
		zlow_c = SW'(zz_c) < w_q;
		if (zero_q) begin
			bad_c = 1'b1;
		end else if (op_s1 == OP_DECODE) begin
			bad_c = AW'(n_s1) >= total_q;
		end else begin
			bad_c = (SW'(x_s1) >= nx_q) || (SW'(y_s1) >= ny_q) || (SW'(zz_c) >= nz_q);
		end

		a1_c = (d3_q && zlow_c && !ylow_c) ? (y_s1 - CB'(w_q)) : y_s1;
		b1_c = (ylow_c && zlow_c) ? oddw_q : nx_q;
		b2_c = zlow_c ? oddplane_q : plane_q;

		add_c = AW'(x_s1);
		if ((d3_q || ylow_c) && zlow_c) begin
			add_c = add_c + zc_q;
		end
		if (d3_q && zlow_c && !ylow_c) begin
			add_c = add_c + AW'(oddww_q);
		end
		if (ylow_c && zlow_c) begin
			add_c = add_c - AW'(w_q);
		end

		mor2_c = '0;
		mor3_c = '0;
		nw_c   = MW'(n_s1);
		for (int b = 0; b < CB; b++) begin
			mor2_c[2*b]   = x_s1[b];
			mor2_c[2*b+1] = y_s1[b];
			mor3_c[3*b]   = x_s1[b];
			mor3_c[3*b+1] = y_s1[b];
			mor3_c[3*b+2] = zz_c[b];
			dmx_c[b] = d3_q ? nw_c[3*b]   : nw_c[2*b];
			dmy_c[b] = d3_q ? nw_c[3*b+1] : nw_c[2*b+1];
			dmz_c[b] = d3_q ? nw_c[3*b+2] : 1'b0;
		end

		nx_a   = AW'(n_s1);
		top_c  = d3_q && (nx_a >= wplane_q);
		num1_c = top_c ? (nx_a - wplane_q) : (nx_a - zc_q);
	end

	logic              vld_s2, bad_s2, emor_s2, dmor_s2, top_s2;
	opcode_t           op_s2;
	logic [IDX_W-1:0]  mor_s2;
	logic [CB-1:0]     dmx_s2, dmy_s2, dmz_s2;
	logic [CB+SW-1:0]  p1_s2;
	logic [CB+PLW-1:0] p2_s2;
	logic [AW-1:0]     add_s2, num1_s2;
	logic [PLW-1:0]    den1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2   <= op_s1;
			bad_s2  <= bad_c;
			emor_s2 <= xlow_c && ylow_c && zlow_c;
			dmor_s2 <= nx_a < zc_q;
			top_s2  <= top_c;
			mor_s2  <= d3_q ? IDX_W'(mor3_c) : IDX_W'(mor2_c);
			dmx_s2  <= dmx_c;
			dmy_s2  <= dmy_c;
			dmz_s2  <= dmz_c;
			p1_s2   <= (CB+SW)'(a1_c) * (CB+SW)'(b1_c);
			p2_s2   <= (CB+PLW)'(zz_c) * (CB+PLW)'(b2_c);
			add_s2  <= add_c;
			num1_s2 <= num1_c;
			// 2D divides by the plane so the quotient is zero and the remainder passes
			den1_s2 <= (top_c || !d3_q) ? plane_q : oddplane_q;
		end
	end

	// ---------------- divider 1: slice ----------------
	pay1_t          pay1_c, pay1_d;
	logic           vld_d1;
	logic [CB-1:0]  q1_d;
	logic [AW-1:0]  r1_d;

	always_comb begin
		pay1_c.op   = op_s2;
		pay1_c.bad  = bad_s2;
		pay1_c.dmor = dmor_s2;
		pay1_c.top  = top_s2;
		pay1_c.eidx = emor_s2 ? mor_s2 : IDX_W'(add_s2 + AW'(p1_s2) + AW'(p2_s2));
		pay1_c.dx   = dmx_s2;
		pay1_c.dy   = dmy_s2;
		pay1_c.dz   = dmz_s2;
	end

	gzic_div #(
		.NW (AW),
		.DW (PLW),
		.QB (CB),
		.PW ($bits(pay1_t))
	) u_div_slice (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s2),
		.num     (num1_s2),
		.den     (den1_s2),
		.pay_in  (pay1_c),
		.out_vld (vld_d1),
		.quo     (q1_d),
		.rem     (r1_d),
		.pay_out (pay1_d)
	);

	// ---------------- stage 3: pick row divisor ----------------
	logic [PLW-1:0] r_c, num2_c;
	logic [SW-1:0]  den2_c;
	logic           lt_c;
	pay2_t          pay2_c;

	always_comb begin
		r_c  = PLW'(r1_d);
		lt_c = (oddw_q != '0) && (r_c < oddww_q);
		pay2_c.p1 = pay1_d;
		if (pay1_d.top) begin
			num2_c     = r_c;
			den2_c     = nx_q;
			pay2_c.oxf = 1'b0;
			pay2_c.oyf = 1'b0;
			pay2_c.oz  = CB'(w_q) + q1_d;
		end else if (lt_c) begin
			num2_c     = r_c;
			den2_c     = oddw_q;
			pay2_c.oxf = 1'b1;
			pay2_c.oyf = 1'b0;
			pay2_c.oz  = d3_q ? q1_d : '0;
		end else begin
			num2_c     = r_c - oddww_q;
			den2_c     = nx_q;
			pay2_c.oxf = 1'b0;
			pay2_c.oyf = 1'b1;
			pay2_c.oz  = d3_q ? q1_d : '0;
		end
	end

	logic           vld_s3;
	logic [PLW-1:0] num2_s3;
	logic [SW-1:0]  den2_s3;
	pay2_t          pay2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num2_s3 <= num2_c;
			den2_s3 <= den2_c;
			pay2_s3 <= pay2_c;
		end
	end

	// ---------------- divider 2: row ----------------
	pay2_t          pay2_d;
	logic           vld_d2;
	logic [CB-1:0]  q2_d;
	logic [PLW-1:0] r2_d;

	gzic_div #(
		.NW (PLW),
		.DW (SW),
		.QB (CB),
		.PW ($bits(pay2_t))
	) u_div_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s3),
		.num     (num2_s3),
		.den     (den2_s3),
		.pay_in  (pay2_s3),
		.out_vld (vld_d2),
		.quo     (q2_d),
		.rem     (r2_d),
		.pay_out (pay2_d)
	);

	// ---------------- stage 4: output register ----------------
	logic [IDX_W-1:0] idx_c, idx_s4;
	logic [CB-1:0]    ox_c, oy_c, oz_c, x_s4, y_s4, z_s4;
	logic             oor_s4;

	always_comb begin
		idx_c = '0;
		ox_c  = '0;
		oy_c  = '0;
		oz_c  = '0;
		if (pay2_d.p1.bad) begin
			idx_c = '0;
		end else if (pay2_d.p1.op == OP_ENCODE) begin
			idx_c = pay2_d.p1.eidx;
		end else if (pay2_d.p1.dmor) begin
			ox_c = pay2_d.p1.dx;
			oy_c = pay2_d.p1.dy;
			oz_c = pay2_d.p1.dz;
		end else begin
			ox_c = CB'(SW'(r2_d) + (pay2_d.oxf ? w_q : '0));
			oy_c = CB'(SW'(q2_d) + (pay2_d.oyf ? w_q : '0));
			oz_c = pay2_d.oz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s4 <= idx_c;
			x_s4   <= ox_c;
			y_s4   <= oy_c;
			z_s4   <= oz_c;
			oor_s4 <= pay2_d.p1.bad;
		end
	end

	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata  = DPAD'({z_s4, y_s4, x_s4, idx_s4});
	assign m_axis_tuser  = oor_s4;

	// ---------------- assertions ----------------
	`GZIC_ASSERT(a_cfg_blocks_input, cfg_we |=> !s_axis_tready)
	`GZIC_NEVER(a_hold_not_ready, (hold_q != '0) && s_axis_tready)
	`GZIC_ASSERT(a_accept_enters, (s_axis_tvalid && s_axis_tready) |=> vld_s1)
	`GZIC_ASSERT(a_oor_zero, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))

endmodule

### bench/tb_grid_zorder_index_codec.sv
// Self-checking bench for the grid Z-order index codec: random and directed encode/decode
// traffic under varying grid sizes, results predicted in-bench and compared in order.
// Depends on gzic_pkg and the grid_zorder_index_codec RTL.
module tb_grid_zorder_index_codec;
	timeunit 1ns;
	timeprecision 1ps;
	import gzic_pkg::*;

	localparam int CB = 10;
	localparam int DW = ((3*CB+IDX_W+7)/8)*8;

	typedef struct packed {
		logic [29:0] index;
		logic [9:0]  x;
		logic [9:0]  y;
		logic [9:0]  z;
		logic        oor;
	} cell_res_t;

	class zorder_scoreboard;
		bit        three_d;
		int        sx, sy, sz;
		cell_res_t pending[$];
		int        errors;

		function longint pow2_floor(longint v);
			longint w;
			w = 1;
			while ((w << 1) <= v) w = w << 1;
			return w;
		endfunction

		function cell_res_t predict(opcode_t op, longint x, longint y, longint z, longint n);
			cell_res_t r;
			longint nx, ny, nz, mn, w, oddw, plane, oddp, total, zc, m, rr, base;
			int dims;
			r = '0;
			nx = longint'((sx > 1024) ? 1024 : sx);
			ny = longint'((sy > 1024) ? 1024 : sy);
			nz = three_d ? longint'((sz > 1024) ? 1024 : sz) : longint'(1);
			dims = three_d ? 3 : 2;
			if (!three_d) z = 0;
			mn = (nx < ny) ? nx : ny;
			if (three_d && nz < mn) mn = nz;
			if (mn == 0) begin
				r.oor = 1'b1;
				return r;
			end
			w = pow2_floor(mn);
			oddw = nx - w;
			plane = nx * ny;
			oddp = plane - w * w;
			total = plane * nz;
			if (op == OP_ENCODE) begin
				if (x >= nx || y >= ny || z >= nz) r.oor = 1'b1;
				else if (x < w && y < w && z < w) begin
					for (int b = 0; b < CB; b++) begin
						r.index[dims*b] = x[b];
						r.index[dims*b+1] = y[b];
						if (three_d) r.index[dims*b+2] = z[b];
					end
				end else if (!three_d)
					r.index = 30'((y < w) ? w*w + y*oddw + (x-w) : y*nx + x);
				else if (z < w) begin
					base = w*w*w + oddp*z;
					r.index = 30'((y < w) ? base + y*oddw + (x-w)
						: base + oddw*w + (y-w)*nx + x);
				end else
					r.index = 30'(z*plane + y*nx + x);
			end else begin
				zc = three_d ? w*w*w : w*w;
				if (n >= total) r.oor = 1'b1;
				else if (n < zc) begin
					for (int b = 0; b < CB; b++) begin
						r.x[b] = n[dims*b];
						r.y[b] = n[dims*b+1];
						if (three_d) r.z[b] = n[dims*b+2];
					end
				end else if (!three_d) begin
					m = n - zc;
					if (oddw != 0 && m < oddw*w) begin
						r.x = 10'(w + m % oddw);
						r.y = 10'(m / oddw);
					end else begin
						m = m - oddw*w;
						r.x = 10'(m % nx);
						r.y = 10'(w + m / nx);
					end
				end else if (n < w*plane) begin
					m = n - zc;
					rr = m % oddp;
					r.z = 10'(m / oddp);
					if (oddw != 0 && rr < oddw*w) begin
						r.x = 10'(w + rr % oddw);
						r.y = 10'(rr / oddw);
					end else begin
						rr = rr - oddw*w;
						r.x = 10'(rr % nx);
						r.y = 10'(w + rr / nx);
					end
				end else begin
					m = n - w*plane;
					rr = m % plane;
					r.z = 10'(w + m / plane);
					r.x = 10'(rr % nx);
					r.y = 10'(rr / nx);
				end
			end
			return r;
		endfunction

		function void note_request(opcode_t op, logic [DW-1:0] d);
			pending = {pending, predict(op, longint'(d[9:0]), longint'(d[19:10]),
				longint'(d[29:20]), longint'(d[59:30]))};
		endfunction

		function void check_result(logic [DW-1:0] d, logic oor);
			cell_res_t e;
			if (pending.size() == 0) begin
				$error("result with no expectation pending");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[29:0] !== e.index) begin
				$error("index_out exp %0d got %0d", e.index, d[29:0]); errors++;
			end
			if (d[39:30] !== e.x) begin
				$error("x_out exp %0d got %0d", e.x, d[39:30]); errors++;
			end
			if (d[49:40] !== e.y) begin
				$error("y_out exp %0d got %0d", e.y, d[49:40]); errors++;
			end
			if (d[59:50] !== e.z) begin
				$error("z_out exp %0d got %0d", e.z, d[59:50]); errors++;
			end
			if (oor !== e.oor) begin
				$error("out_of_range exp %0d got %0d", e.oor, oor); errors++;
			end
		endfunction
	endclass

	logic           clk, arst_n;
	logic           cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [SIZE_W-1:0]    cfg_wdata;
	logic           s_axis_tvalid, s_axis_tready, s_axis_tuser;
	logic [DW-1:0]  s_axis_tdata;
	logic           m_axis_tvalid, m_axis_tready, m_axis_tuser;
	logic [DW-1:0]  m_axis_tdata;

	zorder_scoreboard sb = new();
	int src_idle_pct, snk_idle_pct;

	grid_zorder_index_codec DUT (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("TB_ERROR");
		$finish;
	end

	// receiver: random stall, check each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 0;
		else begin
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// hold the write enable high; setup drops it after the last register
	task automatic write_reg(cfg_reg_t r, int v);
		cfg_we <= 1;
		cfg_idx <= r;
		cfg_wdata <= SIZE_W'(v);
		@(posedge clk);
		if (r == REG_THREE_D) sb.three_d = v[0];
		else if (r == REG_SIZE_X) sb.sx = v;
		else if (r == REG_SIZE_Y) sb.sy = v;
		else sb.sz = v;
	endtask

	task automatic send_item(opcode_t op, int x, int y, int z, int n);
		logic [DW-1:0] d;
		d = {4'b0, n[29:0], z[9:0], y[9:0], x[9:0]};
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(op, d);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// random mix: mostly in-grid requests, some beyond the sides or the cell count
	task automatic random_items(int count);
		int nx, ny, nz, total;
		nx = sb.sx; ny = sb.sy; nz = sb.three_d ? sb.sz : 1;
		total = nx * ny * nz;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0)
				send_item(opcode_t'($urandom_range(1)), $urandom_range(1023),
					$urandom_range(1023), $urandom_range(1023), $urandom_range(30'h3fffffff));
			else if ($urandom_range(1))
				send_item(OP_ENCODE, $urandom_range(nx-1), $urandom_range(ny-1),
					$urandom_range(nz-1), $urandom);
			else
				send_item(OP_DECODE, $urandom, $urandom, $urandom, $urandom_range(total-1));
		end
	endtask

	task automatic setup(bit d3, int x, int y, int z);
		write_reg(REG_THREE_D, d3);
		write_reg(REG_SIZE_X, x);
		write_reg(REG_SIZE_Y, y);
		write_reg(REG_SIZE_Z, z);
		cfg_we <= 0;
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0; cfg_idx = '0; cfg_wdata = '0;
		s_axis_tvalid = 0; s_axis_tuser = 0; s_axis_tdata = '0;
		sb.three_d = 0; sb.sx = 1024; sb.sy = 1024; sb.sz = 1024;
		src_idle_pct = 29; snk_idle_pct = 53;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: reset grid extremes, both ops
		send_item(OP_ENCODE, 0, 0, 0, 0);
		send_item(OP_ENCODE, 1023, 1023, 1023, 0);
		send_item(OP_DECODE, 0, 0, 0, 30'h3fffffff);
		send_item(OP_DECODE, 1023, 1023, 1023, 1048575);
		send_item(OP_DECODE, 0, 0, 0, 1048576);
		drain();
		// odd 2D grid: remainder rows, out-of-range coords, size above span
		setup(0, 13, 2047, 1);
		send_item(OP_ENCODE, 12, 0, 0, 0);
		send_item(OP_ENCODE, 5, 1023, 0, 0);
		send_item(OP_ENCODE, 13, 0, 0, 0);
		send_item(OP_DECODE, 0, 0, 0, 64);
		send_item(OP_DECODE, 0, 0, 0, 13311);
		drain();
		// 3D with remainder slices; zero size
		setup(1, 6, 9, 5);
		send_item(OP_ENCODE, 5, 8, 4, 0);
		send_item(OP_ENCODE, 3, 3, 3, 0);
		send_item(OP_ENCODE, 1, 1, 4, 0);
		send_item(OP_DECODE, 0, 0, 0, 269);
		send_item(OP_DECODE, 0, 0, 0, 64);
		send_item(OP_DECODE, 0, 0, 0, 270);
		drain();
		setup(1, 0, 5, 5);
		send_item(OP_ENCODE, 0, 0, 0, 0);
		send_item(OP_DECODE, 0, 0, 0, 0);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 53 : 0;
			snk_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 29 : 0;
			setup(0, 1024, 1024, 1);
			random_items(60);
			drain();
			setup(1, 1024, 1024, 1024);
			random_items(60);
			drain();
			setup(1, 1, 1, 1);
			random_items(30);
			drain();
			for (int k = 0; k < 5; k++) begin
				setup($urandom_range(1), $urandom_range(1, 1024), $urandom_range(1, 1024),
					$urandom_range(1, 1024));
				random_items(45);
				drain();
			end
		end

		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

### grid_zorder_index_codec.f
+incdir+src
src/gzic_pkg.sv
src/gzic_div.sv
src/grid_zorder_index_codec.sv
bench/tb_grid_zorder_index_codec.sv
